### rtl/dtn_pkg.sv
// ----------------------------------------------------------------------------
// dtn_pkg: shared types and constants
// Record and result beats, controller commands and states.
// ----------------------------------------------------------------------------
package dtn_pkg;

  localparam int unsigned NameBytes      = 32;
  localparam int unsigned DefMaxResults  = 16;
  localparam int unsigned DefTableDepth  = 32;

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  typedef struct packed {
    op_e               opcode;
    logic [63:0]       name_bytes_0_7;
    logic [63:0]       name_bytes_8_15;
    logic [63:0]       name_bytes_16_23;
    logic [63:0]       name_bytes_24_31;
    logic [7:0]        name_length;
    logic signed [7:0] strength_in;
    logic [7:0]        channel_in;
    logic [7:0]        auth_in;
  } in_beat_t;

  typedef struct packed {
    logic [63:0]       out_bytes_0_7;
    logic [63:0]       out_bytes_8_15;
    logic [63:0]       out_bytes_16_23;
    logic [63:0]       out_bytes_24_31;
    logic signed [7:0] strength_out;
    logic [7:0]        channel_out;
    logic [7:0]        auth_out;
    logic              entry_valid;
    logic              last_entry;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RANK,
    ST_EMIT,
    ST_PREP,
    ST_PLAY,
    ST_EMPTY
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;       // capture the input beat, normalize name
    logic scan_step;  // compare one entry, advance index
    logic append;     // write new entry at entry_count
    logic rank_init;  // start ranking at entry i = 0
    logic rank_step;  // compare entry j against i
    logic rank_next;  // advance to next i
    logic emit;       // store result of entry i at its rank
    logic emit_empty; // drive invalid last result
    logic clear;      // empty the table
    logic play_init;  // rewind the result store read
    logic play_step;  // drive one stored result, advance
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_finish;
    logic full;
    logic empty_name;
    logic empty_table;
    logic scan_done;  // index reached entry_count
    logic match;      // entry at index matches
    logic j_done;
    logic i_done;
    logic hit;        // entry i ranks in the emitted window
    logic play_last;  // stored result being read is the last one
  } sts_t;

endpackage

### rtl/dtn_ctrl.sv
// ----------------------------------------------------------------------------
// dtn_ctrl: controller
// Sequences the match scan for adds and the rank/emit pass for a finish.
// ----------------------------------------------------------------------------
module dtn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  dtn_pkg::sts_t sts_i,
  output dtn_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import dtn_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.is_finish) begin
          if (sts_i.empty_table) begin
            state_d = ST_EMPTY;
          end else begin
            cmd_o.rank_init = 1'b1;
            state_d = ST_RANK;
          end
        end else if (sts_i.full || sts_i.empty_name) begin
          state_d = ST_IDLE;
        end else if (sts_i.scan_done) begin
          cmd_o.append = 1'b1;
          state_d = ST_IDLE;
        end else begin
          // match update happens inside scan_step
          cmd_o.scan_step = 1'b1;
          if (sts_i.match) state_d = ST_IDLE;
        end
      end
      ST_RANK: begin
        if (sts_i.j_done) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.rank_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.hit) cmd_o.emit = 1'b1;
        cmd_o.rank_next = 1'b1;
        if (sts_i.i_done) begin
          cmd_o.clear     = 1'b1;
          cmd_o.play_init = 1'b1;
          state_d = ST_PREP;
        end else begin
          state_d = ST_RANK;
        end
      end
      ST_PREP: begin
        // wait state so the store read sees the last rank write
        state_d = ST_PLAY;
      end
      ST_PLAY: begin
        cmd_o.play_step = 1'b1;
        if (sts_i.play_last) state_d = ST_IDLE;
      end
      ST_EMPTY: begin
        cmd_o.emit_empty = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/dtn_data.sv
// ----------------------------------------------------------------------------
// dtn_data: datapath
// Name normalizer, entry table, scan comparator, rank counter, result store.
// ----------------------------------------------------------------------------
module dtn_data #(
  parameter int unsigned MaxResults = dtn_pkg::DefMaxResults,
  parameter int unsigned TableDepth = dtn_pkg::DefTableDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtn_pkg::in_beat_t in_i,
  input  dtn_pkg::cmd_t     cmd_i,
  output dtn_pkg::sts_t     sts_o,
  output logic              strobe_o,
  output dtn_pkg::out_beat_t res_o
);
  import dtn_pkg::*;

  localparam int unsigned IdxW    = $clog2(TableDepth);
  localparam int unsigned CntW    = $clog2(TableDepth + 1);
  localparam int unsigned EmitCap = (MaxResults < TableDepth) ? MaxResults : TableDepth;
  localparam int unsigned OutW    = (EmitCap > 1) ? $clog2(EmitCap) : 1;

  // Entry table and rank-ordered result store, registered reads.
  logic [NameBytes*8-1:0] name_mem [TableDepth];
  logic [7:0]             str_mem  [TableDepth];
  logic [7:0]             chn_mem  [TableDepth];
  logic [7:0]             aut_mem  [TableDepth];
  out_beat_t              out_mem  [EmitCap];

  logic [CntW-1:0] count_q;
  logic [CntW-1:0] idx_q, idx_d;   // scan index / rank i
  logic [CntW-1:0] j_q, j_d;
  logic [CntW-1:0] rank_q;
  logic [OutW-1:0] play_q, play_d;
  logic            is_fin_q;
  logic [NameBytes*8-1:0] name_q;
  logic signed [7:0] str_q;
  logic [7:0]        chn_q, aut_q;

  // Read data: entry at idx_q, strength at j_q, stored result at play_q.
  logic [NameBytes*8-1:0] rd_name_q;
  logic signed [7:0]      rd_str_q, rd_sj_q;
  logic [7:0]             rd_chn_q, rd_aut_q;
  out_beat_t              rd_ob_q;
  out_beat_t              ob_w, empty_beat;

  // Normalize: clip length, cut at first zero byte.
  logic [NameBytes*8-1:0] raw, norm;
  always_comb begin
    logic ended;
    ended = 1'b0;
    raw   = {in_i.name_bytes_24_31, in_i.name_bytes_16_23,
             in_i.name_bytes_8_15, in_i.name_bytes_0_7};
    norm  = '0;
    for (int b = 0; b < NameBytes; b++) begin
      if (in_i.name_length <= 8'(b) || raw[b*8 +: 8] == 8'h00) ended = 1'b1;
      if (!ended) norm[b*8 +: 8] = raw[b*8 +: 8];
    end
  end

  // Next indices; the memories are read at the next index so that the
  // read data always belongs to the current one.
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load || cmd_i.rank_init) begin
      idx_d = '0;
    end else if (cmd_i.scan_step || cmd_i.rank_next) begin
      idx_d = idx_q + CntW'(1);
    end
  end

  always_comb begin
    j_d = j_q;
    if (cmd_i.rank_init || cmd_i.rank_next) begin
      j_d = '0;
    end else if (cmd_i.rank_step) begin
      j_d = j_q + CntW'(1);
    end
  end

  always_comb begin
    play_d = play_q;
    if (cmd_i.play_init) begin
      play_d = '0;
    end else if (cmd_i.play_step) begin
      play_d = play_q + OutW'(1);
    end
  end

  logic [IdxW-1:0] rd_idx, rd_addr, j_addr;
  assign rd_idx  = idx_q[IdxW-1:0];
  assign rd_addr = idx_d[IdxW-1:0];
  assign j_addr  = j_d[IdxW-1:0];

  logic [CntW-1:0] emit_n;
  assign emit_n = (count_q > CntW'(EmitCap)) ? CntW'(EmitCap) : count_q;

  logic match;
  assign match = (rd_name_q == name_q);

  always_comb begin
    sts_o             = '0;
    sts_o.is_finish   = is_fin_q;
    sts_o.full        = (count_q >= CntW'(TableDepth));
    sts_o.empty_name  = (name_q[7:0] == 8'h00);
    sts_o.empty_table = (count_q == '0);
    sts_o.scan_done   = (idx_q >= count_q);
    sts_o.match       = match;
    sts_o.j_done      = (j_q >= count_q);
    sts_o.i_done      = (idx_q + CntW'(1) >= count_q);
    sts_o.hit         = (rank_q < emit_n);
    sts_o.play_last   = rd_ob_q.last_entry;
  end

  always_comb begin
    ob_w                 = '0;
    ob_w.out_bytes_0_7   = rd_name_q[63:0];
    ob_w.out_bytes_8_15  = rd_name_q[127:64];
    ob_w.out_bytes_16_23 = rd_name_q[191:128];
    ob_w.out_bytes_24_31 = rd_name_q[255:192];
    ob_w.strength_out    = rd_str_q;
    ob_w.channel_out     = rd_chn_q;
    ob_w.auth_out        = rd_aut_q;
    ob_w.entry_valid     = 1'b1;
    ob_w.last_entry      = (rank_q == emit_n - CntW'(1));
  end

  always_comb begin
    empty_beat            = '0;
    empty_beat.last_entry = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      j_q      <= '0;
      rank_q   <= '0;
      play_q   <= '0;
      is_fin_q <= 1'b0;
      strobe_o <= 1'b0;
    end else begin
      strobe_o <= cmd_i.play_step | cmd_i.emit_empty;
      idx_q    <= idx_d;
      j_q      <= j_d;
      play_q   <= play_d;
      if (cmd_i.load) is_fin_q <= (in_i.opcode == OP_FINISH);
      if (cmd_i.append) count_q <= count_q + CntW'(1);
      if (cmd_i.clear) count_q <= '0;
      if (cmd_i.rank_init || cmd_i.rank_next) begin
        rank_q <= '0;
      end else if (cmd_i.rank_step) begin
        if (rd_sj_q > rd_str_q || (rd_sj_q == rd_str_q && j_q < idx_q)) begin
          rank_q <= rank_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      name_q <= norm;
      str_q  <= in_i.strength_in;
      chn_q  <= in_i.channel_in;
      aut_q  <= in_i.auth_in;
    end
    if (cmd_i.scan_step && match && (str_q > rd_str_q)) begin
      str_mem[rd_idx] <= str_q;
      chn_mem[rd_idx] <= chn_q;
      aut_mem[rd_idx] <= aut_q;
    end
    if (cmd_i.append) begin
      name_mem[count_q[IdxW-1:0]] <= name_q;
      str_mem[count_q[IdxW-1:0]]  <= str_q;
      chn_mem[count_q[IdxW-1:0]]  <= chn_q;
      aut_mem[count_q[IdxW-1:0]]  <= aut_q;
    end
    if (cmd_i.emit) out_mem[rank_q[OutW-1:0]] <= ob_w;

    rd_name_q <= name_mem[rd_addr];
    rd_str_q  <= str_mem[rd_addr];
    rd_chn_q  <= chn_mem[rd_addr];
    rd_aut_q  <= aut_mem[rd_addr];
    rd_sj_q   <= str_mem[j_addr];
    rd_ob_q   <= out_mem[play_d];

    if (cmd_i.play_step) begin
      res_o <= rd_ob_q;
    end else if (cmd_i.emit_empty) begin
      res_o <= empty_beat;
    end
  end

endmodule

### rtl/dedup_top_n_by_strength.sv
// ----------------------------------------------------------------------------
// dedup_top_n_by_strength: deduplicating top-N table by strength
// Keeps named records, merges duplicates, emits strongest-first on finish.
// ----------------------------------------------------------------------------
// Usage:
//   Present a record beat on rec_i and raise start; it is taken on the
//   edge where start is high and busy is low. An add beat normalizes the
//   name, then scans the stored entries one per cycle for a match; the scan
//   loop over the entry table decides when the next beat can be taken.
//   A finish beat ranks every entry by counting stronger or earlier equal
//   entries, one compare a cycle, with an emit step after each entry. The
//   top MaxResults ranked entries land in a rank-ordered result store, then
//   are played out one beat a cycle on res_o with valid_o high for exactly
//   one cycle each, the last marked last_entry; the first beat follows the
//   last emit step, a prep state and the registered output stage.
//   An empty table gives a single invalid beat marked last, from the empty
//   state through the output register. The receiver cannot stall; beats are
//   delivered unconditionally. After a finish the table is empty.
//   Reset empties the table and returns the controller to idle; stored
//   names are not cleared, since only entries below the count are read.
// ----------------------------------------------------------------------------
module dedup_top_n_by_strength #(
  parameter int unsigned MaxResults = dtn_pkg::DefMaxResults,
  parameter int unsigned TableDepth = dtn_pkg::DefTableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  dtn_pkg::in_beat_t  rec_i,
  output logic               valid_o,
  output dtn_pkg::out_beat_t res_o
);
  import dtn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The controller only looks at start while idle, which is when busy is low.
  dtn_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // Result beats leave the datapath registered, one strobe per beat.
  dtn_data #(
    .MaxResults(MaxResults),
    .TableDepth(TableDepth)
  ) u_data (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (rec_i),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .strobe_o(valid_o),
    .res_o   (res_o)
  );

endmodule

### tb/sv/dtn_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtn_result_checker: top-N table predictor and result comparator
// Watches accepted record beats, keeps its own table of named entries and
// predicts the strongest-first result beats of each finish.
// ----------------------------------------------------------------------------
module dtn_result_checker #(
  parameter int unsigned MaxResults = dtn_pkg::DefMaxResults,
  parameter int unsigned TableDepth = dtn_pkg::DefTableDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  dtn_pkg::in_beat_t  rec_i,
  input  logic               valid_i,
  input  dtn_pkg::out_beat_t res_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import dtn_pkg::*;

  logic [255:0]      tbl_name [TableDepth];
  logic signed [7:0] tbl_str  [TableDepth];
  logic [7:0]        tbl_chan [TableDepth];
  logic [7:0]        tbl_auth [TableDepth];
  int unsigned       tbl_count;
  out_beat_t         expected_beats[$];

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  function automatic logic [255:0] clean_name(in_beat_t r);
    logic [255:0] raw, norm;
    int unsigned  lim;
    bit           ended;
    raw = {r.name_bytes_24_31, r.name_bytes_16_23, r.name_bytes_8_15, r.name_bytes_0_7};
    lim = (r.name_length > 32) ? 32 : r.name_length;
    norm = '0;
    ended = 0;
    for (int b = 0; b < 32; b++) begin
      if (b >= lim || raw[b*8 +: 8] == 8'h00) ended = 1;
      if (!ended) norm[b*8 +: 8] = raw[b*8 +: 8];
    end
    return norm;
  endfunction

  task automatic merge_record(in_beat_t r);
    logic [255:0] nm;
    if (tbl_count >= TableDepth) return;
    nm = clean_name(r);
    if (nm[7:0] == 8'h00) return;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_name[i] == nm) begin
        if (r.strength_in > tbl_str[i]) begin
          tbl_str[i]  = r.strength_in;
          tbl_chan[i] = r.channel_in;
          tbl_auth[i] = r.auth_in;
        end
        return;
      end
    end
    tbl_name[tbl_count] = nm;
    tbl_str[tbl_count]  = r.strength_in;
    tbl_chan[tbl_count] = r.channel_in;
    tbl_auth[tbl_count] = r.auth_in;
    tbl_count++;
  endtask

  task automatic rank_and_flush();
    out_beat_t   ranked[TableDepth];
    out_beat_t   b;
    int unsigned n_emit, rank;
    if (tbl_count == 0) begin
      b = '0;
      b.last_entry = 1'b1;
      expected_beats.push_back(b);
      return;
    end
    n_emit = (tbl_count > MaxResults) ? MaxResults : tbl_count;
    for (int i = 0; i < tbl_count; i++) begin
      rank = 0;
      for (int j = 0; j < tbl_count; j++)
        if (tbl_str[j] > tbl_str[i] || (tbl_str[j] == tbl_str[i] && j < i)) rank++;
      b = '0;
      {b.out_bytes_24_31, b.out_bytes_16_23, b.out_bytes_8_15, b.out_bytes_0_7} = tbl_name[i];
      b.strength_out = tbl_str[i];
      b.channel_out  = tbl_chan[i];
      b.auth_out     = tbl_auth[i];
      b.entry_valid  = 1'b1;
      b.last_entry   = (rank == n_emit - 1);
      ranked[rank] = b;
    end
    for (int k = 0; k < n_emit; k++) expected_beats.push_back(ranked[k]);
    tbl_count = 0;
  endtask

  task automatic compare_beat(out_beat_t got);
    out_beat_t e;
    if (expected_beats.size() == 0) begin
      report_mismatch("result beat with nothing expected");
      return;
    end
    e = expected_beats.pop_front();
    if (got.out_bytes_0_7 !== e.out_bytes_0_7)     report_mismatch("out_bytes_0_7");
    if (got.out_bytes_8_15 !== e.out_bytes_8_15)   report_mismatch("out_bytes_8_15");
    if (got.out_bytes_16_23 !== e.out_bytes_16_23) report_mismatch("out_bytes_16_23");
    if (got.out_bytes_24_31 !== e.out_bytes_24_31) report_mismatch("out_bytes_24_31");
    if (got.strength_out !== e.strength_out) begin
      report_mismatch($sformatf("strength_out %0d exp %0d", got.strength_out, e.strength_out));
    end
    if (got.channel_out !== e.channel_out) report_mismatch("channel_out");
    if (got.auth_out !== e.auth_out)       report_mismatch("auth_out");
    if (got.entry_valid !== e.entry_valid) report_mismatch("entry_valid");
    if (got.last_entry !== e.last_entry)   report_mismatch("last_entry");
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    tbl_count    = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_i) compare_beat(res_i);
      if (start_i && !busy_i) begin
        if (rec_i.opcode == OP_FINISH) rank_and_flush();
        else merge_record(rec_i);
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

### tb/sv/dedup_top_n_by_strength_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dedup_top_n_by_strength_test: top-level bench for the top-N table
// Drives add and finish beats, directed corner cases first, then random
// scan sessions over a small name pool; a checker module predicts results.
// ----------------------------------------------------------------------------
module dedup_top_n_by_strength_test;
  import dtn_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_beat_t  rec_i;
  logic      valid_o;
  out_beat_t res_o;
  int        fail_count;
  int        pending;
  int        idle_cycles;
  int        n_sent;
  bit        quiet_stretch;

  dedup_top_n_by_strength u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .rec_i   (rec_i),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

  dtn_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .rec_i        (rec_i),
    .valid_i      (valid_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: count cycles with no beat moving either way.
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random fill for every field of a record beat.
  function automatic in_beat_t rand_beat();
    logic [319:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom, $urandom};
    return in_beat_t'(bits[$bits(in_beat_t)-1:0]);
  endfunction

  // Present one beat and hold it until the edge that takes it; start drops
  // only where an idle gap follows, so it never toggles within one step.
  task automatic send_beat(input in_beat_t b);
    rec_i = b;
    start = 1'b1;
    do @(posedge clk_i); while (busy);
    n_sent++;
    @(negedge clk_i);
    if (!quiet_stretch && $urandom_range(99) < 8) begin
      start = 1'b0;
      rec_i = rand_beat();
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  // Build a name of given printable length, padded with junk past the end.
  function automatic in_beat_t make_add(input int unsigned seed_name, input int unsigned len,
                                        input logic [7:0] rep_len, input logic signed [7:0] s);
    in_beat_t     b;
    logic [255:0] nm;
    for (int i = 0; i < 32; i++) begin
      nm[i*8 +: 8] = (i < len) ? 8'(8'h41 + ((seed_name * 7 + i * 3) % 50)) : 8'($urandom);
    end
    b.opcode = OP_ADD;
    {b.name_bytes_24_31, b.name_bytes_16_23, b.name_bytes_8_15, b.name_bytes_0_7} = nm;
    b.name_length = rep_len;
    b.strength_in = s;
    b.channel_in  = 8'($urandom);
    b.auth_in     = 8'($urandom);
    return b;
  endfunction

  function automatic in_beat_t make_finish();
    in_beat_t b;
    b = rand_beat();
    b.opcode = OP_FINISH;
    return b;
  endfunction

  function automatic in_beat_t make_noise();
    in_beat_t b;
    b = rand_beat();
    b.opcode = OP_ADD;
    return b;
  endfunction

  initial begin
    in_beat_t b;
    int       session;
    int       lenpick;
    idle_cycles   = 0;
    n_sent        = 0;
    quiet_stretch = 1'b0;
    start  = 1'b0;
    rec_i  = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: finish on an empty table.
    send_beat(make_finish());
    // Empty names: zero length, and a zero first byte.
    send_beat(make_add(1, 10, 8'd0, 8'sd5));
    b = make_add(1, 10, 8'd10, 8'sd5);
    b.name_bytes_0_7[7:0] = 8'h00;
    send_beat(b);
    // Full 32-byte name with length past 32, extremes of strength.
    b = make_add(2, 32, 8'd255, 8'sh80);
    b.name_bytes_24_31[63:56] = 8'hFF;
    send_beat(b);
    send_beat(make_add(3, 32, 8'd32, 8'sd127));
    // Embedded zero byte ends the name early.
    b = make_add(4, 20, 8'd20, 8'sd0);
    b.name_bytes_8_15[7:0] = 8'h00;
    send_beat(b);
    // Duplicate with equal, then lower, then higher strength.
    send_beat(make_add(5, 6, 8'd6, 8'sd10));
    send_beat(make_add(5, 6, 8'd6, 8'sd10));
    send_beat(make_add(5, 6, 8'd6, -8'sd20));
    send_beat(make_add(5, 6, 8'd6, 8'sd11));
    // Equal strengths keep insertion order.
    send_beat(make_add(6, 3, 8'd3, 8'sd0));
    send_beat(make_add(7, 1, 8'd1, 8'sd0));
    send_beat(make_finish());
    // Fill past the table depth, then a duplicate while full; emits the top.
    for (int i = 0; i < DefTableDepth + 2; i++) begin
      send_beat(make_add(10 + i, 1 + i % 32, 8'(1 + i % 32), 8'($urandom)));
    end
    send_beat(make_add(10, 1, 8'd1, 8'sd127));
    send_beat(make_finish());

    // Random sessions over a small pool so that duplicates are common.
    session = 0;
    while (n_sent < 210) begin
      int n_add;
      quiet_stretch = (session % 5 == 2);
      n_add = (session % 7 == 3) ? $urandom_range(30, 40) : $urandom_range(0, 20);
      if (n_add > 209 - n_sent) n_add = 209 - n_sent;
      for (int i = 0; i < n_add; i++) begin
        if ($urandom_range(99) < 10) begin
          b = make_noise();
        end else begin
          lenpick = $urandom_range(1, 32);
          b = make_add($urandom_range(0, 11), lenpick,
                       ($urandom_range(3) == 0) ? 8'($urandom) : 8'(lenpick),
                       8'($urandom));
        end
        send_beat(b);
      end
      send_beat(make_finish());
      session++;
    end
    start = 1'b0;

    // Drain: wait for outstanding results, then for the block to settle.
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
